>>> rtl/core/dds_pkg.sv
// Shared constants, codes and table builder for the DDS waveform generator.
package dds_pkg;

    localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;
    localparam int unsigned PHASE_W = 32;
    localparam int unsigned ENTRY_W = 11;
    localparam int unsigned AMP_W = 10;
    localparam int unsigned PROD_W = ENTRY_W + AMP_W;

    localparam logic [ENTRY_W-1:0] FULL_CODE = ENTRY_W'(1309);
    localparam logic [AMP_W-1:0] AMP_FULL = AMP_W'(1000);

    localparam int unsigned RECIP_SHIFT = 31;
    localparam longint unsigned AMP_DIV = 1000;
    localparam int unsigned RECIP_W = 22;
    localparam logic [RECIP_W-1:0] AMP_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + AMP_DIV - 64'd1) / AMP_DIV);

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_AMPLITUDE   = 2'd1,
        CFG_WAVE_SELECT = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SILENT   = 2'd3
    } wave_sel_t;

    typedef struct packed {
        logic      load;
        wave_sel_t wave;
    } dds_lut_ctrl_t;

    // First-quadrant sine entry pair {upper half, lower half} for index j
    function automatic logic [2*ENTRY_W-1:0] sine_pair(input int unsigned j,
                                                       input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] base;
        logic [63:0] delta;
        logic [63:0] pos;
        logic [63:0] neg;
        x = (64'(j) * TWO_PI_Q30) >> bits;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd20;
        sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd72;
        sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd156;
        sum = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum = (sum > term) ? sum - term : 64'd0;
        if (sum > ONE_Q30)
        begin
            sum = ONE_Q30;
        end
        base = 64'(FULL_CODE) * ONE_Q30;
        delta = 64'(FULL_CODE) * sum;
        pos = (base + delta) >> 31;
        neg = (base - delta) >> 31;
        return {pos[ENTRY_W-1:0], neg[ENTRY_W-1:0]};
    endfunction

endpackage

>>> rtl/core/dds_wave_lut.sv
// Registered waveform table lookup: sine, square, triangle or silence.
module dds_wave_lut
    import dds_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic                                 clk,
    input  dds_lut_ctrl_t                        ctrl,
    input  logic [$clog2(TABLE_DEPTH + 1)-2:0]   idx,
    output logic [ENTRY_W-1:0]                   entry
);

    localparam int unsigned IDX_BITS = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int unsigned QUARTER = 1 << (IDX_BITS - 2);
    localparam logic [IDX_BITS-1:0] HALF = IDX_BITS'(1) << (IDX_BITS - 1);
    localparam logic [IDX_BITS-2:0] QUARTER_IDX = (IDX_BITS - 1)'(QUARTER);
    localparam int unsigned TRI_W = IDX_BITS + ENTRY_W;

    logic [2*ENTRY_W-1:0] sine_rom [QUARTER];

    for (genvar g = 0; g < QUARTER; g++)
    begin : g_rom
        assign sine_rom[g] = sine_pair(g, IDX_BITS);
    end

    logic [IDX_BITS-2:0]  fold_raw;
    logic [IDX_BITS-2:0]  fold;
    logic                 peak;
    logic [2*ENTRY_W-1:0] pair;
    logic [ENTRY_W-1:0]   sine_val;
    logic [IDX_BITS-1:0]  tri_r;
    logic [TRI_W-1:0]     tri_prod;
    logic [ENTRY_W-1:0]   tri_val;
    logic [ENTRY_W-1:0]   entry_next;
    logic [ENTRY_W-1:0]   entry_reg;

    always_comb
    begin
        fold_raw = idx[IDX_BITS-2:0];
        fold = (fold_raw > QUARTER_IDX) ? (~fold_raw + 1'b1) : fold_raw;
        peak = (fold == QUARTER_IDX);
        pair = sine_rom[fold[IDX_BITS-3:0]];
        if (peak)
        begin
            sine_val = idx[IDX_BITS-1] ? '0 : FULL_CODE;
        end
        else
        begin
            sine_val = idx[IDX_BITS-1] ? pair[ENTRY_W-1:0] : pair[2*ENTRY_W-1:ENTRY_W];
        end

        tri_r = (idx <= HALF) ? idx : (~idx + 1'b1);
        tri_prod = TRI_W'(tri_r) * TRI_W'(FULL_CODE);
        tri_val = ENTRY_W'(tri_prod >> (IDX_BITS - 1));

        case (ctrl.wave)
            WAVE_SINE:     entry_next = sine_val;
            WAVE_SQUARE:   entry_next = idx[IDX_BITS-1] ? '0 : FULL_CODE;
            WAVE_TRIANGLE: entry_next = tri_val;
            default:       entry_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

>>> rtl/core/dds_waveform_generator_core.sv
// Top level of the DDS waveform generator: phase accumulator, lookup and scaling pipeline.
//
// One sample tick is taken every clock unless tick_stall holds it off; the rate is one
// item per cycle while nothing stalls, set by the 32-bit phase adder that closes the
// accumulator loop. Restart clears the phase before the tick's lookup, the top index
// bits of the phase address a quarter-wave sine table (square and triangle are formed
// directly), and the entry is scaled by amplitude/1000 with a floor. Amplitudes above
// 1000 act as 1000; wave select 3 gives zero while the phase still advances. Configuration
// writes are always ready and belong to idle periods.
module dds_waveform_generator_core
    import dds_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [PHASE_W-1:0]  cfg_data,

    input  logic                tick_valid,
    output logic                tick_stall,
    input  logic                restart,

    output logic                sample_valid,
    input  logic                sample_stall,
    output logic [ENTRY_W-1:0]  sample
);

    localparam int unsigned IDX_BITS = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int unsigned SCALED_W = PROD_W + RECIP_W;

    logic [PHASE_W-1:0]  phase_step_reg;
    logic [AMP_W-1:0]    amplitude_reg;
    wave_sel_t           wave_select_reg;

    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_cur;
    logic [PHASE_W-1:0]  phase_next;

    logic                s1_valid_reg;
    logic                s2_valid_reg;
    logic                s3_valid_reg;
    logic                sample_valid_reg;
    logic [IDX_BITS-1:0] s1_idx_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [ENTRY_W-1:0]  sample_reg;
    logic [ENTRY_W-1:0]  sample_next;
    logic [SCALED_W-1:0] scaled;
    logic [AMP_W-1:0]    amp_eff;
    logic [ENTRY_W-1:0]  entry;

    logic                out_ready;
    logic                s3_ready;
    logic                s2_ready;
    logic                s1_ready;
    logic                accept;
    dds_lut_ctrl_t       lut_ctrl;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        out_ready = !sample_valid_reg || !sample_stall;
        s3_ready = !s3_valid_reg || out_ready;
        s2_ready = !s2_valid_reg || s3_ready;
        s1_ready = !s1_valid_reg || s2_ready;
        accept = tick_valid && s1_ready;

        phase_cur = restart ? '0 : phase_reg;
        phase_next = phase_cur + phase_step_reg;

        lut_ctrl.load = s1_valid_reg && s2_ready;
        lut_ctrl.wave = wave_select_reg;

        amp_eff = (amplitude_reg > AMP_FULL) ? AMP_FULL : amplitude_reg;
        prod_next = PROD_W'(entry) * PROD_W'(amp_eff);

        scaled = SCALED_W'(prod_reg) * SCALED_W'(AMP_RECIP);
        sample_next = scaled[RECIP_SHIFT +: ENTRY_W];
    end

    assign tick_stall = !s1_ready;

    dds_wave_lut #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_lut (
        .clk   (clk),
        .ctrl  (lut_ctrl),
        .idx   (s1_idx_reg),
        .entry (entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            amplitude_reg <= AMP_FULL;
            wave_select_reg <= WAVE_SINE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:  phase_step_reg <= cfg_data;
                CFG_AMPLITUDE:   amplitude_reg <= cfg_data[AMP_W-1:0];
                CFG_WAVE_SELECT: wave_select_reg <= wave_sel_t'(cfg_data[1:0]);
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= tick_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                sample_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg <= phase_cur[PHASE_W-1 -: IDX_BITS];
        end
        if (s2_valid_reg && s3_ready)
        begin
            prod_reg <= prod_next;
        end
        if (s3_valid_reg && out_ready)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample_valid = sample_valid_reg;
    assign sample = sample_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> phase_reg == $past(phase_step_reg))
        else $error("phase not restarted from zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg))
        else $error("phase moved without an item");

    assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && sample_valid_reg)
        else $error("input stalled with a free pipeline slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid_reg |-> sample_reg <= FULL_CODE)
        else $error("sample beyond full code");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the DDS waveform generator core.
module tb_top
    import dds_pkg::*;
();

    localparam int unsigned DEPTH = 1024;
    localparam int unsigned HALF = DEPTH / 2;
    localparam int unsigned QUARTER = DEPTH / 4;
    localparam int unsigned IDX_W = 10;
    localparam logic [63:0] PEAK = 64'd1309;
    localparam logic [63:0] TAU_Q30 = 64'd6746518852;
    localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned QUIET_LIMIT = 2000;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = 2'd0;
    logic [PHASE_W-1:0]  cfg_data = '0;
    logic                tick_valid = 1'b0;
    logic                tick_stall;
    logic                restart = 1'b0;
    logic                sample_valid;
    logic                sample_stall = 1'b0;
    logic [ENTRY_W-1:0]  sample;

    logic [PHASE_W-1:0]  acc_phase = '0;
    logic [PHASE_W-1:0]  step_word = '0;
    logic [AMP_W-1:0]    amp_level = AMP_W'(1000);
    wave_sel_t           wave_mode = WAVE_SINE;
    logic [ENTRY_W-1:0]  expected_samples[$];
    logic [ENTRY_W-1:0]  want;
    int                  error_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  quiet_cycles = 0;

    dds_waveform_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .restart      (restart),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] quarter_sine(input logic [63:0] j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        int          k;
        x = (j * TAU_Q30) / DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = (acc > term) ? acc - term : 64'd0;
            else
                acc = acc + term;
        end
        return (acc > UNIT_Q30) ? UNIT_Q30 : acc;
    endfunction

    function automatic logic [63:0] wave_code(input wave_sel_t w, input int unsigned i);
        int unsigned j;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] v;
        case (w)
            WAVE_SQUARE:
                return (i < HALF) ? PEAK : 64'd0;
            WAVE_TRIANGLE:
            begin
                r = (i <= HALF) ? 64'(i) : 64'(DEPTH - i);
                return (r * PEAK) / HALF;
            end
            WAVE_SINE:
            begin
                j = i & (HALF - 1);
                if (j > QUARTER)
                    j = HALF - j;
                s = (j == QUARTER) ? UNIT_Q30 : quarter_sine(64'(j));
                if (i < HALF)
                    v = PEAK * UNIT_Q30 + PEAK * s;
                else
                    v = PEAK * UNIT_Q30 - PEAK * s;
                return v >> 31;
            end
            default:
                return 64'd0;
        endcase
    endfunction

    function automatic logic [ENTRY_W-1:0] scaled_sample(input int unsigned i);
        logic [63:0] amp;
        amp = (amp_level > AMP_W'(1000)) ? 64'd1000 : 64'(amp_level);
        return ENTRY_W'((wave_code(wave_mode, i) * amp) / 64'd1000);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && tick_valid && !tick_stall)
        begin
            if (restart)
                acc_phase = '0;
            expected_samples.push_back(scaled_sample(32'(acc_phase[PHASE_W-1 -: IDX_W])));
            acc_phase = acc_phase + step_word;
        end
        if (rst_n && sample_valid && !sample_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: sample %0d with none expected", $time, sample);
                error_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample !== want)
                begin
                    $display("%0t: sample mismatch: expected %0d, actual %0d",
                             $time, want, sample);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
        sample_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if ((tick_valid && !tick_stall) || (sample_valid && !sample_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_tick(input logic restart_bit);
        tick_valid <= 1'b1;
        restart <= restart_bit;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tick_valid <= 1'b0;
            restart <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
    endtask

    task automatic settle();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PHASE_STEP:  step_word = value;
            CFG_AMPLITUDE:   amp_level = value[AMP_W-1:0];
            CFG_WAVE_SELECT: wave_mode = wave_sel_t'(value[1:0]);
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_table_points();
        int w;
        settle();
        write_reg(CFG_PHASE_STEP, 32'h4000_0000);
        for (w = 0; w < 4; w++)
        begin
            settle();
            write_reg(CFG_WAVE_SELECT, 32'(w));
            send_tick(1'b1);
            send_tick(1'b0);
            send_tick(1'b0);
            send_tick(1'b0);
        end
    endtask

    task automatic test_phase_wrap();
        settle();
        write_reg(CFG_WAVE_SELECT, 32'(WAVE_TRIANGLE));
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    task automatic test_amplitude_limits();
        settle();
        write_reg(CFG_WAVE_SELECT, 32'(WAVE_SQUARE));
        write_reg(CFG_PHASE_STEP, 32'h0);
        write_reg(CFG_AMPLITUDE, 32'd0);
        send_tick(1'b1);
        settle();
        write_reg(CFG_AMPLITUDE, 32'd1023);
        send_tick(1'b1);
        settle();
        write_reg(CFG_AMPLITUDE, 32'd1);
        send_tick(1'b1);
        settle();
        write_reg(CFG_AMPLITUDE, 32'd1000);
        send_tick(1'b1);
    endtask

    task automatic test_unused_index();
        settle();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_tick(1'b1);
    endtask

    task automatic randomise_config();
        logic [31:0] step;
        logic [31:0] amp;
        case ($urandom_range(0, 3))
            0: step = $urandom_range(0, 1 << 24);
            1: step = $urandom;
            2: step = {10'($urandom_range(0, 1023)), 22'd0};
            default: step = 32'hFFFF_FFFF - $urandom_range(0, 1 << 24);
        endcase
        case ($urandom_range(0, 4))
            0: amp = 32'd0;
            1: amp = 32'd1000;
            2: amp = $urandom_range(1001, 1023);
            default: amp = $urandom_range(0, 1023);
        endcase
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_AMPLITUDE, ($urandom & ~32'h3FF) | amp);
        write_reg(CFG_WAVE_SELECT, ($urandom & ~32'h3) | $urandom_range(0, 3));
    endtask

    task automatic test_random_phases();
        int mode;
        int blk;
        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (blk = 0; blk < 4; blk++)
            begin
                settle();
                randomise_config();
                repeat (110)
                    send_tick($urandom_range(0, 19) == 0);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_table_points();
        test_phase_wrap();
        test_amplitude_limits();
        test_unused_index();
        test_random_phases();
        settle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
